// File: src/gmi_pkg.sv
// ----------------------------------------------------------------------------
// gmi_pkg: shared types for the gcd / modular inverse unit
// Operation codes and the command and status groups between the controller
// and the datapath.
// ----------------------------------------------------------------------------
package gmi_pkg;

	typedef enum logic {
		OP_GCD = 1'b0,
		OP_INV = 1'b1
	} op_t;

	typedef struct packed {
		logic load;
		logic div_init;
		logic div_step;
		logic acc_step;
		logic negate;
		logic update;
		logic out_load;
	} gmi_cmd_t;

	typedef struct packed {
		logic r1_zero;
		logic no_modulus;
	} gmi_stat_t;

endpackage

// File: src/gmi_req_if.sv
// ----------------------------------------------------------------------------
// gmi_req_if: request channel
// Valid/ready channel carrying the operation code and both operands.
// ----------------------------------------------------------------------------
interface gmi_req_if #(parameter int W = 32);
	logic         valid;
	logic         ready;
	logic         op;
	logic [W-1:0] operand_a;
	logic [W-1:0] operand_b;

	modport source (output valid, output op, output operand_a, output operand_b, input ready);
	modport sink   (input valid, input op, input operand_a, input operand_b, output ready);
endinterface

// File: src/gmi_rsp_if.sv
// ----------------------------------------------------------------------------
// gmi_rsp_if: response channel
// Valid/ready channel carrying the result value and the found flag.
// ----------------------------------------------------------------------------
interface gmi_rsp_if #(parameter int W = 32);
	logic         valid;
	logic         ready;
	logic [W-1:0] value;
	logic         found;

	modport source (output valid, output value, output found, input ready);
	modport sink   (input valid, input value, input found, output ready);
endinterface

// File: src/gmi_datapath.sv
// ----------------------------------------------------------------------------
// gmi_datapath: Euclid datapath
// Remainder pair, modular coefficient pair, a bit-serial restoring divider
// and a quotient-times-coefficient accumulator reduced modulo the modulus.
// ----------------------------------------------------------------------------
module gmi_datapath
	import gmi_pkg::*;
#(
	parameter int W = 32
) (
	input  logic         clk,
	input  gmi_cmd_t     cmd,
	input  logic         op,
	input  logic [W-1:0] operand_a,
	input  logic [W-1:0] operand_b,
	output gmi_stat_t    stat,
	output logic [W-1:0] value,
	output logic         found
);

	logic         op_q;
	logic         first_q;
	logic [W-1:0] r0_q, r1_q, t0_q, t1_q, m_q;
	logic [W-1:0] rem_q, dvd_q, qt_q;
	logic         qbit_q;

	logic [W:0]   shifted, shifted_sub;
	logic         ge;
	logic [W:0]   dbl_sum, dbl_red, acc_sum, acc_red, tn_sum, tn_red;
	logic [W-1:0] qt_dbl, qt_acc, tn;
	logic         inv_ok;

	always_comb begin
		shifted     = {rem_q, dvd_q[W-1]};
		shifted_sub = shifted - {1'b0, r1_q};
		ge          = shifted >= {1'b0, r1_q};

		dbl_sum = {1'b0, qt_q} + {1'b0, qt_q};
		dbl_red = dbl_sum - {1'b0, m_q};
		qt_dbl  = (dbl_sum >= {1'b0, m_q}) ? dbl_red[W-1:0] : dbl_sum[W-1:0];

		acc_sum = {1'b0, qt_q} + {1'b0, t1_q};
		acc_red = acc_sum - {1'b0, m_q};
		qt_acc  = (acc_sum >= {1'b0, m_q}) ? acc_red[W-1:0] : acc_sum[W-1:0];

		tn_sum = {1'b0, t0_q} + {1'b0, qt_q};
		tn_red = tn_sum - {1'b0, m_q};
		tn     = (tn_sum >= {1'b0, m_q}) ? tn_red[W-1:0] : tn_sum[W-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= op;
			first_q <= (op_t'(op) == OP_INV);
			r0_q    <= operand_a;
			r1_q    <= operand_b;
			m_q     <= operand_b;
		end
		if (cmd.div_init) begin
			rem_q <= '0;
			dvd_q <= r0_q;
			qt_q  <= '0;
		end
		if (cmd.div_step) begin
			rem_q  <= ge ? shifted_sub[W-1:0] : shifted[W-1:0];
			dvd_q  <= {dvd_q[W-2:0], 1'b0};
			qbit_q <= ge;
			qt_q   <= qt_dbl;
		end
		if (cmd.acc_step && qbit_q) begin
			qt_q <= qt_acc;
		end
		if (cmd.negate) begin
			qt_q <= (qt_q == '0) ? '0 : (m_q - qt_q);
		end
		if (cmd.update) begin
			r0_q <= r1_q;
			r1_q <= rem_q;
			if (first_q) begin
				t0_q    <= '0;
				t1_q    <= W'(1);
				first_q <= 1'b0;
			end else begin
				t0_q <= t1_q;
				t1_q <= tn;
			end
		end
	end

	always_comb begin
		stat.r1_zero    = (r1_q == '0);
		stat.no_modulus = (op_t'(op_q) == OP_INV) && (m_q[W-1:1] == '0);
		inv_ok          = !stat.no_modulus && (r0_q == W'(1));
		if (op_t'(op_q) == OP_GCD) begin
			value = r0_q;
			found = 1'b1;
		end else begin
			value = inv_ok ? t0_q : '0;
			found = inv_ok;
		end
	end

endmodule

// File: src/gmi_ctrl.sv
// ----------------------------------------------------------------------------
// gmi_ctrl: sequencing controller
// Walks the Euclid loop: one remainder step per division, each division
// done one quotient bit at a time, then negation and coefficient update.
// ----------------------------------------------------------------------------
module gmi_ctrl
	import gmi_pkg::*;
#(
	parameter int W = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  logic      out_free,
	input  gmi_stat_t stat,
	output gmi_cmd_t  cmd
);

	localparam int CntW = $clog2(W);

	typedef enum logic [7:0] {
		S_IDLE     = 8'b0000_0001,
		S_CHECK    = 8'b0000_0010,
		S_DIV_INIT = 8'b0000_0100,
		S_STEP     = 8'b0000_1000,
		S_ACC      = 8'b0001_0000,
		S_NEG      = 8'b0010_0000,
		S_UPDATE   = 8'b0100_0000,
		S_DONE     = 8'b1000_0000
	} state_t;

	state_t            state_q, state_d;
	logic [CntW-1:0]   cnt_q;
	logic              last;

	assign last = (cnt_q == CntW'(W - 1));

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_CHECK;
				end
			end
			S_CHECK: begin
				if (stat.no_modulus || stat.r1_zero) begin
					state_d = S_DONE;
				end else begin
					state_d = S_DIV_INIT;
				end
			end
			S_DIV_INIT: begin
				cmd.div_init = 1'b1;
				state_d      = S_STEP;
			end
			S_STEP: begin
				cmd.div_step = 1'b1;
				state_d      = S_ACC;
			end
			S_ACC: begin
				cmd.acc_step = 1'b1;
				state_d      = last ? S_NEG : S_STEP;
			end
			S_NEG: begin
				cmd.negate = 1'b1;
				state_d    = S_UPDATE;
			end
			S_UPDATE: begin
				cmd.update = 1'b1;
				state_d    = S_CHECK;
			end
			S_DONE: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_DIV_INIT) begin
				cnt_q <= '0;
			end else if (state_q == S_ACC && !last) begin
				cnt_q <= cnt_q + CntW'(1);
			end
		end
	end

endmodule

// File: src/gcd_and_modular_inverse_unit.sv
// ----------------------------------------------------------------------------
// gcd_and_modular_inverse_unit: Euclidean gcd and modular inverse
// Each remainder step runs the bit-serial divider one quotient bit at a time.
// One request in flight; the next can be taken once the result is
// registered. Reset clears the controller and the response valid flag.
// ----------------------------------------------------------------------------
module gcd_and_modular_inverse_unit
	import gmi_pkg::*;
#(
	parameter int OPERAND_WIDTH = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	gmi_req_if.sink    req,
	gmi_rsp_if.source  rsp
);

	gmi_cmd_t                 cmd;
	gmi_stat_t                stat;
	logic [OPERAND_WIDTH-1:0] dp_value;
	logic                     dp_found;
	logic                     out_free;
	logic                     rsp_valid_q;
	logic [OPERAND_WIDTH-1:0] rsp_value_q;
	logic                     rsp_found_q;

	assign out_free = !rsp_valid_q || rsp.ready;

	gmi_ctrl #(.W(OPERAND_WIDTH)) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.out_free (out_free),
		.stat     (stat),
		.cmd      (cmd)
	);

	gmi_datapath #(.W(OPERAND_WIDTH)) u_datapath (
		.clk       (clk),
		.cmd       (cmd),
		.op        (req.op),
		.operand_a (req.operand_a),
		.operand_b (req.operand_b),
		.stat      (stat),
		.value     (dp_value),
		.found     (dp_found)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			rsp_value_q <= dp_value;
			rsp_found_q <= dp_found;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.value = rsp_value_q;
	assign rsp.found = rsp_found_q;

`ifndef SYNTHESIS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("request taken while a transaction is in flight");

	a_not_found_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.found |-> rsp.value == '0)
		else $error("value nonzero with found clear");

	a_rsp_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp.valid) |-> $past(cmd.out_load))
		else $error("response raised without a finished transaction");
`endif

endmodule
